/* rtl/assert_macros.svh */
// assertion macros shared by the checker files
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle
`define AFC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("afc assertion failed");

// consequent checked in the next cycle
`define AFC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("afc assertion failed");

`endif

/* rtl/afc_pkg.sv */
// types, constants and helpers of the autorange frequency counter
// no dependencies
package afc_pkg;

	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 27;
	localparam int GATE_TICKS_W = 24;
	localparam int GATE_SCALE_W = 10;
	localparam int TICK_RATE_W  = 27;
	localparam int PRESCALE_W   = 9;
	localparam int THRESH_W     = 20;
	localparam int OFFSET_W     = 4;
	localparam int PHASE_W      = 8;
	localparam int FREQ_W       = 32;
	localparam int MUL_B_W      = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GATE_TICKS  = 3'd0,
		CFG_GATE_SCALE  = 3'd1,
		CFG_TICK_RATE   = 3'd2,
		CFG_PRESCALE    = 3'd3,
		CFG_THRESHOLD   = 3'd4,
		CFG_CAL_OFFSET  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [GATE_TICKS_W-1:0] gate_ticks;
		logic [GATE_SCALE_W-1:0] gate_scale;
		logic [TICK_RATE_W-1:0]  tick_rate;
		logic [PRESCALE_W-1:0]   prescale;
		logic [THRESH_W-1:0]     range_threshold_hz;
		logic [OFFSET_W-1:0]     calibration_offset;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		gate_ticks:         24'd100000,
		gate_scale:         10'd10,
		tick_rate:          27'd1000000,
		prescale:           9'd4,
		range_threshold_hz: 20'd1000,
		calibration_offset: 4'd1
	};

	// measurement handed from front to back
	typedef struct packed {
		logic is_period;
		logic zero;
	} job_ctrl_t;

	// mode decision returned from back to front
	typedef struct packed {
		logic valid;
		logic period_mode;
	} mode_fb_t;

	typedef enum logic {
		FR_RUN,
		FR_WAIT
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_FIN
	} back_state_t;

	// zero acts as one, above 256 clamps to 256
	function automatic logic [PRESCALE_W-1:0] eff_prescale(input logic [PRESCALE_W-1:0] ps);
		logic [PRESCALE_W-1:0] r;
		if (ps == '0)
			r = 9'd1;
		else if (ps > 9'd256)
			r = 9'd256;
		else
			r = ps;
		return r;
	endfunction

endpackage

/* rtl/afc_queue.sv */
// two-entry queue of measurement jobs between front and back
// no package dependency
module afc_queue #(
	parameter int DATA_W = 34
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	output logic              empty,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    count_q;

	assign full     = (count_q == (PTR_W+1)'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop && !empty)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/afc_front.sv */
// front part: takes ticks, counts edges or timestamps periods, queues finished measurements
// depends on afc_pkg
module afc_front #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick_valid,
	output logic                   tick_ready,
	input  logic                   edge_req,
	input  logic                   abort,
	input  afc_pkg::cfg_t          cfg,
	input  afc_pkg::mode_fb_t      mode_fb,
	input  logic                   queue_full,
	output logic                   push,
	output afc_pkg::job_ctrl_t     push_ctrl,
	output logic [COUNT_WIDTH-1:0] push_count
);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	afc_pkg::front_state_t state_q, state_d;

	logic                                  mode_q, mode_d;
	logic [afc_pkg::GATE_TICKS_W-1:0]      elapsed_q, elapsed_d;
	logic [COUNT_WIDTH-1:0]                edges_q, edges_d;
	logic [afc_pkg::PHASE_W-1:0]           phase_q, phase_d;
	logic [COUNT_WIDTH-1:0]                steps_q, steps_d;
	logic                                  captured_q, captured_d;

	logic [afc_pkg::PRESCALE_W-1:0]        ps_eff;
	logic [afc_pkg::PHASE_W:0]             phase_inc;
	logic [afc_pkg::PHASE_W-1:0]           phase_adv;
	logic [COUNT_WIDTH-1:0]                steps_adv;
	logic [afc_pkg::GATE_TICKS_W-1:0]      elapsed_inc;
	logic [COUNT_WIDTH-1:0]                edges_inc;

	assign ps_eff      = afc_pkg::eff_prescale(cfg.prescale);
	assign phase_inc   = {1'b0, phase_q} + 1'b1;
	assign elapsed_inc = elapsed_q + 1'b1;
	assign edges_inc   = (edge_req && edges_q != COUNT_MAX) ? edges_q + 1'b1 : edges_q;

	// prescaled timestamp advance once the first edge is seen
	always_comb begin
		phase_adv = phase_q;
		steps_adv = steps_q;
		if (captured_q) begin
			if (phase_inc >= ps_eff) begin
				phase_adv = '0;
				if (steps_q != COUNT_MAX)
					steps_adv = steps_q + 1'b1;
			end else begin
				phase_adv = phase_inc[afc_pkg::PHASE_W-1:0];
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		elapsed_d  = elapsed_q;
		edges_d    = edges_q;
		phase_d    = phase_q;
		steps_d    = steps_q;
		captured_d = captured_q;
		tick_ready = 1'b0;
		push       = 1'b0;
		push_ctrl  = '{is_period: 1'b0, zero: 1'b0};
		push_count = '0;
		unique case (state_q)
			afc_pkg::FR_RUN: begin
				tick_ready = !queue_full;
				if (tick_valid && !queue_full) begin
					if (abort) begin
						mode_d     = 1'b0;
						elapsed_d  = '0;
						edges_d    = '0;
						phase_d    = '0;
						steps_d    = '0;
						captured_d = 1'b0;
					end else if (!mode_q) begin
						if (elapsed_inc >= cfg.gate_ticks) begin
							push       = 1'b1;
							push_count = edges_inc;
							elapsed_d  = '0;
							edges_d    = '0;
							state_d    = afc_pkg::FR_WAIT;
						end else begin
							elapsed_d = elapsed_inc;
							edges_d   = edges_inc;
						end
					end else begin
						if (!edge_req) begin
							phase_d = phase_adv;
							steps_d = steps_adv;
						end else if (!captured_q) begin
							captured_d = 1'b1;
							phase_d    = '0;
							steps_d    = '0;
						end else begin
							push       = 1'b1;
							push_ctrl  = '{is_period: 1'b1, zero: (steps_adv == '0)};
							push_count = steps_adv;
							phase_d    = '0;
							steps_d    = '0;
							captured_d = 1'b0;
							state_d    = afc_pkg::FR_WAIT;
						end
					end
				end
			end
			afc_pkg::FR_WAIT: begin
				if (mode_fb.valid) begin
					mode_d  = mode_fb.period_mode;
					state_d = afc_pkg::FR_RUN;
				end
			end
			default: state_d = afc_pkg::FR_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= afc_pkg::FR_RUN;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			elapsed_q  <= '0;
			edges_q    <= '0;
			phase_q    <= '0;
			steps_q    <= '0;
			captured_q <= 1'b0;
		end else begin
			mode_q     <= mode_d;
			elapsed_q  <= elapsed_d;
			edges_q    <= edges_d;
			phase_q    <= phase_d;
			steps_q    <= steps_d;
			captured_q <= captured_d;
		end
	end

endmodule

/* rtl/afc_back.sv */
// back part: scales gate counts, divides for period results, picks the next mode
// depends on afc_pkg
module afc_back #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  afc_pkg::cfg_t                      cfg,
	input  logic                               queue_empty,
	output logic                               pop,
	input  afc_pkg::job_ctrl_t                 pop_ctrl,
	input  logic [COUNT_WIDTH-1:0]             pop_count,
	output afc_pkg::mode_fb_t                  mode_fb,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic [afc_pkg::FREQ_W-1:0]         frequency_hz,
	output logic                               from_period_mode,
	output logic                               zero_period
);

	localparam int DW     = COUNT_WIDTH + afc_pkg::MUL_B_W;
	localparam int NUM_W  = afc_pkg::TICK_RATE_W;
	localparam int CMP_W  = (DW > NUM_W + 1) ? DW : NUM_W + 1;
	localparam int EXT_W  = (DW > afc_pkg::FREQ_W) ? DW : afc_pkg::FREQ_W + 1;
	localparam int ITER_W = $clog2(NUM_W);

	afc_pkg::back_state_t state_q, state_d;

	logic                          job_period_q;
	logic                          job_zero_q;
	logic [COUNT_WIDTH-1:0]        count_q;
	logic [DW-1:0]                 prod_q;
	logic [NUM_W-1:0]              rem_q;
	logic [NUM_W-1:0]              num_q;
	logic [ITER_W-1:0]             iter_q;

	logic                          result_valid_q;
	logic [afc_pkg::FREQ_W-1:0]    freq_out_q;
	logic                          period_out_q;
	logic                          zero_out_q;

	logic                          load;
	logic [afc_pkg::MUL_B_W-1:0]   mul_b;
	logic [NUM_W:0]                rem_sh;
	logic [CMP_W-1:0]              rem_ext;
	logic [CMP_W-1:0]              den_ext;
	logic [CMP_W-1:0]              diff;
	logic                          q_bit;
	logic [NUM_W-1:0]              rem_next;
	logic [EXT_W-1:0]              prod_ext;
	logic [afc_pkg::FREQ_W-1:0]    gate_freq;
	logic [afc_pkg::FREQ_W-1:0]    period_freq;
	logic [afc_pkg::FREQ_W-1:0]    freq_sel;
	logic                          next_mode;

	assign mul_b = job_period_q
		? afc_pkg::MUL_B_W'(afc_pkg::eff_prescale(cfg.prescale))
		: cfg.gate_scale;

	// one restoring division step
	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign rem_ext  = CMP_W'(rem_sh);
	assign den_ext  = CMP_W'(prod_q);
	assign q_bit    = (rem_ext >= den_ext);
	assign diff     = rem_ext - den_ext;
	assign rem_next = q_bit ? diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];

	// result selection and range decision
	assign prod_ext    = EXT_W'(prod_q);
	assign gate_freq   = (|prod_ext[EXT_W-1:afc_pkg::FREQ_W]) ? '1
		: prod_ext[afc_pkg::FREQ_W-1:0];
	assign period_freq = afc_pkg::FREQ_W'(num_q) + afc_pkg::FREQ_W'(cfg.calibration_offset);
	assign freq_sel    = job_zero_q ? '0 : (job_period_q ? period_freq : gate_freq);
	assign next_mode   = !job_zero_q
		&& (freq_sel < afc_pkg::FREQ_W'(cfg.range_threshold_hz));

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		load    = 1'b0;
		mode_fb = '{valid: 1'b0, period_mode: 1'b0};
		unique case (state_q)
			afc_pkg::BK_IDLE: begin
				if (!queue_empty) begin
					pop     = 1'b1;
					state_d = afc_pkg::BK_MUL;
				end
			end
			afc_pkg::BK_MUL: begin
				state_d = (job_period_q && !job_zero_q) ? afc_pkg::BK_DIV : afc_pkg::BK_FIN;
			end
			afc_pkg::BK_DIV: begin
				if (iter_q == '0)
					state_d = afc_pkg::BK_FIN;
			end
			afc_pkg::BK_FIN: begin
				if (!result_valid_q || result_ready) begin
					load    = 1'b1;
					mode_fb = '{valid: 1'b1, period_mode: next_mode};
					state_d = afc_pkg::BK_IDLE;
				end
			end
			default: state_d = afc_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= afc_pkg::BK_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_period_q <= pop_ctrl.is_period;
			job_zero_q   <= pop_ctrl.zero;
			count_q      <= pop_count;
		end
		if (state_q == afc_pkg::BK_MUL) begin
			prod_q <= DW'(count_q) * DW'(mul_b);
			rem_q  <= '0;
			num_q  <= cfg.tick_rate;
			iter_q <= ITER_W'(NUM_W - 1);
		end
		if (state_q == afc_pkg::BK_DIV) begin
			rem_q  <= rem_next;
			num_q  <= {num_q[NUM_W-2:0], q_bit};
			iter_q <= iter_q - 1'b1;
		end
		if (load) begin
			freq_out_q   <= freq_sel;
			period_out_q <= job_period_q;
			zero_out_q   <= job_zero_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (load)
			result_valid_q <= 1'b1;
		else if (result_ready)
			result_valid_q <= 1'b0;
	end

	assign result_valid     = result_valid_q;
	assign frequency_hz     = freq_out_q;
	assign from_period_mode = period_out_q;
	assign zero_period      = zero_out_q;

endmodule

/* rtl/autorange_frequency_counter.sv */
// one tick a cycle while measuring; after the tick that ends a measurement no tick is taken
// until the back part has the result: a gate result after the multiply, a period result after
// a 27-step restoring division, one quotient bit per cycle; the result then sits in an
// output register, once that is free, which frees the front for the next measurement
// asynchronous active-low reset returns counters, mode and configuration to their defaults
// top level: configuration registers, front, job queue and back; depends on afc_pkg
module autorange_frequency_counter #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             tick_valid,
	output logic                             tick_ready,
	input  logic                             edge_req,
	input  logic                             abort,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [afc_pkg::FREQ_W-1:0]       frequency_hz,
	output logic                             from_period_mode,
	output logic                             zero_period,
	input  logic                             cfg_we,
	input  logic [afc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [afc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int JOB_W = COUNT_WIDTH + $bits(afc_pkg::job_ctrl_t);

	afc_pkg::cfg_t          cfg_q;
	afc_pkg::mode_fb_t      mode_fb;
	afc_pkg::job_ctrl_t     push_ctrl;
	afc_pkg::job_ctrl_t     pop_ctrl;
	logic                   push;
	logic                   pop;
	logic                   queue_full;
	logic                   queue_empty;
	logic [COUNT_WIDTH-1:0] push_count;
	logic [COUNT_WIDTH-1:0] pop_count;
	logic [JOB_W-1:0]       pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= afc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (afc_pkg::cfg_idx_t'(cfg_index))
				afc_pkg::CFG_GATE_TICKS: cfg_q.gate_ticks <= cfg_data[afc_pkg::GATE_TICKS_W-1:0];
				afc_pkg::CFG_GATE_SCALE: cfg_q.gate_scale <= cfg_data[afc_pkg::GATE_SCALE_W-1:0];
				afc_pkg::CFG_TICK_RATE:  cfg_q.tick_rate <= cfg_data[afc_pkg::TICK_RATE_W-1:0];
				afc_pkg::CFG_PRESCALE:   cfg_q.prescale <= cfg_data[afc_pkg::PRESCALE_W-1:0];
				afc_pkg::CFG_THRESHOLD:
					cfg_q.range_threshold_hz <= cfg_data[afc_pkg::THRESH_W-1:0];
				afc_pkg::CFG_CAL_OFFSET:
					cfg_q.calibration_offset <= cfg_data[afc_pkg::OFFSET_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	afc_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.edge_req   (edge_req),
		.abort      (abort),
		.cfg        (cfg_q),
		.mode_fb    (mode_fb),
		.queue_full (queue_full),
		.push       (push),
		.push_ctrl  (push_ctrl),
		.push_count (push_count)
	);

	afc_queue #(
		.DATA_W(JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_ctrl, push_count}),
		.full      (queue_full),
		.empty     (queue_empty),
		.pop       (pop),
		.pop_data  (pop_data)
	);

	assign pop_ctrl  = afc_pkg::job_ctrl_t'(pop_data[JOB_W-1:COUNT_WIDTH]);
	assign pop_count = pop_data[COUNT_WIDTH-1:0];

	afc_back #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.queue_empty      (queue_empty),
		.pop              (pop),
		.pop_ctrl         (pop_ctrl),
		.pop_count        (pop_count),
		.mode_fb          (mode_fb),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.frequency_hz     (frequency_hz),
		.from_period_mode (from_period_mode),
		.zero_period      (zero_period)
	);

endmodule

/* rtl/afc_checker.sv */
// port-level checks for the autorange frequency counter, bound to the top level
// depends on assert_macros.svh and afc_pkg
`include "assert_macros.svh"

module afc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       tick_ready,
	input logic                       result_valid,
	input logic                       result_ready,
	input logic [afc_pkg::FREQ_W-1:0] frequency_hz,
	input logic                       from_period_mode,
	input logic                       zero_period
);

	// stalled result holds
	`AFC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(frequency_hz))

	// zero period only from period mode and reads as zero hertz
	`AFC_ASSERT_SAME(a_zero_period, result_valid && zero_period, frequency_hz == '0 && from_period_mode)

	// a new result is only produced while ticks are held off
	`AFC_ASSERT_SAME(a_result_after_stall, $rose(result_valid), !$past(tick_ready))

	// the mode decision is not ready in the cycle after tick_ready falls
	`AFC_ASSERT_NEXT(a_stall_min, $fell(tick_ready), !tick_ready)

endmodule

bind autorange_frequency_counter afc_checker u_afc_checker (.*);

/* test/autorange_frequency_counter_test.sv */
`timescale 1ns / 100ps
// self-checking testbench of autorange_frequency_counter: a tracker class predicts each
// reading from the accepted ticks and checks the block's results in order
// depends on afc_pkg and the autorange_frequency_counter top level
module autorange_frequency_counter_test;

	localparam int COUNT_W       = 32;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic [afc_pkg::FREQ_W-1:0] freq;
		logic                       from_period;
		logic                       zero;
	} reading_t;

	class freq_tracker;
		afc_pkg::cfg_t                  regs;
		bit                             period_mode;
		bit [afc_pkg::GATE_TICKS_W-1:0] gate_elapsed;
		bit [COUNT_W-1:0]               edge_total;
		bit [afc_pkg::PRESCALE_W-1:0]   phase;
		bit [COUNT_W-1:0]               period_steps;
		bit                             armed;
		reading_t                       pending_readings[$];
		int                             mismatches;

		function new();
			regs = afc_pkg::CFG_RESET;
			period_mode = 1'b0;
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			gate_elapsed = '0;
			edge_total = '0;
			phase = '0;
			period_steps = '0;
			armed = 1'b0;
		endfunction

		function void write_reg(afc_pkg::cfg_idx_t idx, logic [afc_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				afc_pkg::CFG_GATE_TICKS: regs.gate_ticks = d[afc_pkg::GATE_TICKS_W-1:0];
				afc_pkg::CFG_GATE_SCALE: regs.gate_scale = d[afc_pkg::GATE_SCALE_W-1:0];
				afc_pkg::CFG_TICK_RATE:  regs.tick_rate = d[afc_pkg::TICK_RATE_W-1:0];
				afc_pkg::CFG_PRESCALE:   regs.prescale = d[afc_pkg::PRESCALE_W-1:0];
				afc_pkg::CFG_THRESHOLD:
					regs.range_threshold_hz = d[afc_pkg::THRESH_W-1:0];
				afc_pkg::CFG_CAL_OFFSET:
					regs.calibration_offset = d[afc_pkg::OFFSET_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_tick(bit edge_seen, bit abort_seen);
			reading_t          r;
			longint unsigned   f;
			longint unsigned   ps;
			r.from_period = period_mode;
			r.zero = 1'b0;
			f = '0;
			if (abort_seen) begin
				period_mode = 1'b0;
				clear();
				return;
			end
			if (!period_mode) begin
				if (edge_seen && edge_total != '1)
					edge_total = edge_total + 1'b1;
				gate_elapsed = gate_elapsed + 1'b1;
				if (gate_elapsed < regs.gate_ticks)
					return;
				f = longint'(edge_total) * longint'(regs.gate_scale);
				if (f > 64'hFFFF_FFFF)
					f = 64'hFFFF_FFFF;
				period_mode = (f < longint'(regs.range_threshold_hz));
			end else begin
				// zero counts as one, anything past 256 as 256
				if (regs.prescale == '0)
					ps = 64'd1;
				else if (regs.prescale > 9'd256)
					ps = 64'd256;
				else
					ps = 64'(regs.prescale);
				if (armed) begin
					phase = phase + 1'b1;
					if (phase >= ps) begin
						phase = '0;
						if (period_steps != '1)
							period_steps = period_steps + 1'b1;
					end
				end
				if (!edge_seen)
					return;
				if (!armed) begin
					armed = 1'b1;
					phase = '0;
					period_steps = '0;
					return;
				end
				if (period_steps == '0) begin
					f = '0;
					r.zero = 1'b1;
					period_mode = 1'b0;
				end else begin
					f = longint'(regs.tick_rate) / (longint'(period_steps) * ps)
						+ longint'(regs.calibration_offset);
					if (f > 64'hFFFF_FFFF)
						f = 64'hFFFF_FFFF;
					period_mode = (f < longint'(regs.range_threshold_hz));
				end
			end
			clear();
			r.freq = f[afc_pkg::FREQ_W-1:0];
			pending_readings.push_back(r);
		endfunction

		function void check_reading(logic [afc_pkg::FREQ_W-1:0] freq, logic fpm, logic zp);
			reading_t exp_r;
			if (pending_readings.size() == 0) begin
				$error("unexpected result: frequency_hz %0d", freq);
				mismatches++;
				return;
			end
			exp_r = pending_readings.pop_front();
			if (freq !== exp_r.freq) begin
				$error("frequency_hz expected %0d actual %0d", exp_r.freq, freq);
				mismatches++;
			end
			if (fpm !== exp_r.from_period) begin
				$error("from_period_mode expected %0d actual %0d", exp_r.from_period, fpm);
				mismatches++;
			end
			if (zp !== exp_r.zero) begin
				$error("zero_period expected %0d actual %0d", exp_r.zero, zp);
				mismatches++;
			end
		endfunction

		function int pending();
			return pending_readings.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           tick_valid;
	logic                           tick_ready;
	logic                           edge_req;
	logic                           abort;
	logic                           result_valid;
	logic                           result_ready;
	logic [afc_pkg::FREQ_W-1:0]     frequency_hz;
	logic                           from_period_mode;
	logic                           zero_period;
	logic                           cfg_we;
	logic [afc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [afc_pkg::CFG_DATA_W-1:0] cfg_data;

	freq_tracker tracker;
	bit          no_idle;
	bit          hold_off_req;
	int          cycle_count;

	autorange_frequency_counter #(
		.COUNT_WIDTH(COUNT_W)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.tick_valid       (tick_valid),
		.tick_ready       (tick_ready),
		.edge_req         (edge_req),
		.abort            (abort),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.frequency_hz     (frequency_hz),
		.from_period_mode (from_period_mode),
		.zero_period      (zero_period),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			tracker.check_reading(frequency_hz, from_period_mode, zero_period);
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				result_ready <= no_idle || ($urandom_range(99) >= 32);
			end
		end
	end

	task automatic send_tick(bit e, bit a);
		tick_valid <= 1'b1;
		edge_req <= e;
		abort <= a;
		do @(posedge clk); while (!tick_ready);
		tracker.note_tick(e, a);
	endtask

	task automatic idle_gap();
		while (!no_idle && $urandom_range(99) < 32) begin
			tick_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_readings_done();
		tick_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(afc_pkg::cfg_idx_t idx, logic [afc_pkg::CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		tracker.write_reg(idx, d);
	endtask

	task automatic program_counter(int unsigned gt, int unsigned gs, int unsigned tr,
			int unsigned ps, int unsigned th, int unsigned off);
		write_reg(afc_pkg::CFG_GATE_TICKS, afc_pkg::CFG_DATA_W'(gt));
		write_reg(afc_pkg::CFG_GATE_SCALE, afc_pkg::CFG_DATA_W'(gs));
		write_reg(afc_pkg::CFG_TICK_RATE, afc_pkg::CFG_DATA_W'(tr));
		write_reg(afc_pkg::CFG_PRESCALE, afc_pkg::CFG_DATA_W'(ps));
		write_reg(afc_pkg::CFG_THRESHOLD, afc_pkg::CFG_DATA_W'(th));
		write_reg(afc_pkg::CFG_CAL_OFFSET, afc_pkg::CFG_DATA_W'(off));
		cfg_we <= 1'b0;
	endtask

	// pulse train with random spacing, a little edge noise and rare aborts
	task automatic run_pulses(int n, int max_gap, int hold_at, int pause_at);
		int gap_left;
		bit e;
		bit a;
		gap_left = $urandom_range(max_gap);
		for (int i = 0; i < n; i++) begin
			e = (gap_left == 0);
			if (e)
				gap_left = $urandom_range(max_gap);
			else
				gap_left--;
			if ($urandom_range(9) == 0)
				e = 1'($urandom_range(1));
			a = ($urandom_range(49) == 0);
			if (i == hold_at)
				hold_off_req = 1'b1;
			if (i == pause_at)
				wait_readings_done();
			idle_gap();
			send_tick(e, a);
		end
	endtask

	initial begin
		tracker = new();
		no_idle = 1'b0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		tick_valid <= 1'b0;
		edge_req <= 1'b0;
		abort <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_counter(4, 10, 1000, 2, 1000, 1);
		// gate into period mode, period reading, zero period
		send_tick(1'b1, 1'b0); send_tick(1'b1, 1'b0); send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0); send_tick(1'b1, 1'b0); send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0); send_tick(1'b0, 1'b0); send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0); send_tick(1'b1, 1'b0);
		// abort in gate mode, then abort with an edge in period mode
		send_tick(1'b1, 1'b0); send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0); send_tick(1'b0, 1'b0); send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0); send_tick(1'b1, 1'b0); send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		// empty gate
		send_tick(1'b0, 1'b0); send_tick(1'b0, 1'b0); send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		wait_readings_done();

		program_counter(8, 10, 1000000, 4, 1000, 1);
		run_pulses(120, 12, 30, 80);
		wait_readings_done();

		no_idle = 1'b1;
		program_counter(1, 1000, 134217727, 1, 1048575, 15);
		run_pulses(80, 10, -1, -1);
		wait_readings_done();
		no_idle = 1'b0;

		// zero registers
		program_counter(0, 0, 0, 0, 0, 0);
		run_pulses(40, 1, -1, -1);
		wait_readings_done();

		program_counter(16, 1, 5000, 511, 1000000, 7);
		run_pulses(200, 400, -1, -1);
		wait_readings_done();

		program_counter(5, 3, 2000, 3, 100000, 2);
		run_pulses(80, 15, -1, -1);
		wait_readings_done();

		program_counter(12, 100, 100000000, 256, 500000, 3);
		run_pulses(40, 20, -1, -1);
		wait_readings_done();

		program_counter(16777215, 10, 1000000, 4, 1000, 1);
		run_pulses(30, 6, -1, -1);
		idle_gap();
		send_tick(1'b0, 1'b1);
		wait_readings_done();

		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
